// File: hdl/voxel_corner_occlusion_light_macros.svh
// assertion macros shared by the voxel corner occlusion light block
`ifndef VOXEL_CORNER_OCCLUSION_LIGHT_MACROS_SVH
`define VOXEL_CORNER_OCCLUSION_LIGHT_MACROS_SVH

// same-cycle implication, disabled during reset
`define VCOL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vcol assertion failed");

// next-cycle implication, disabled during reset
`define VCOL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vcol assertion failed");

`endif

// File: hdl/vcol_pkg.sv
// types, constants and neighbour tables of the voxel corner occlusion light block
package vcol_pkg;

  localparam int NUM_FACES   = 6;
  localparam int NUM_CORNERS = 4;
  localparam int NUM_NBRS    = 27;
  localparam int WORD_W      = 36;
  localparam int NIB_W       = 4;

  localparam logic [2:0] FIRST_FACE = 3'd0;
  localparam logic [2:0] LAST_FACE  = 3'd5;
  localparam logic [4:0] CENTRE_NBR = 5'd13;
  localparam logic [3:0] LIGHT_FULL_LEVEL = 4'd15;
  localparam logic [6:0] AO_MAX     = 7'd32;
  localparam logic [9:0] FULL_LIGHT = 10'd600;

  typedef logic [2:0] face_t;
  typedef logic [1:0] corner_t;
  typedef logic [4:0] nbr_t;

  // the held neighbourhood, nibble n of light and shade at [4n+3:4n]
  typedef struct packed {
    logic [NUM_NBRS-1:0]        opaque;
    logic [3*WORD_W-1:0]        light;
    logic [3*WORD_W-1:0]        shade;
  } nbhd_t;

  // what one corner lane finds
  typedef struct packed {
    logic [5:0] ao;
    logic [5:0] light;
  } lane_res_t;

  // corner, side, side per face and corner
  localparam nbr_t OCC_TRI [NUM_FACES][NUM_CORNERS][3] = '{
    '{'{5'd0,  5'd1,  5'd3 }, '{5'd2,  5'd1,  5'd5 }, '{5'd6,  5'd3,  5'd7 },
      '{5'd8,  5'd5,  5'd7 }},
    '{'{5'd18, 5'd19, 5'd21}, '{5'd20, 5'd19, 5'd23}, '{5'd24, 5'd21, 5'd25},
      '{5'd26, 5'd23, 5'd25}},
    '{'{5'd6,  5'd7,  5'd15}, '{5'd8,  5'd7,  5'd17}, '{5'd24, 5'd15, 5'd25},
      '{5'd26, 5'd17, 5'd25}},
    '{'{5'd0,  5'd1,  5'd9 }, '{5'd2,  5'd1,  5'd11}, '{5'd18, 5'd9,  5'd19},
      '{5'd20, 5'd11, 5'd19}},
    '{'{5'd0,  5'd3,  5'd9 }, '{5'd6,  5'd3,  5'd15}, '{5'd18, 5'd9,  5'd21},
      '{5'd24, 5'd15, 5'd21}},
    '{'{5'd2,  5'd5,  5'd11}, '{5'd8,  5'd5,  5'd17}, '{5'd20, 5'd11, 5'd23},
      '{5'd26, 5'd17, 5'd23}}
  };

  // four quad neighbours summed for shade and light
  localparam nbr_t OCC_QUAD [NUM_FACES][NUM_CORNERS][4] = '{
    '{'{5'd0,  5'd1,  5'd3,  5'd4 }, '{5'd1,  5'd2,  5'd4,  5'd5 },
      '{5'd3,  5'd4,  5'd6,  5'd7 }, '{5'd4,  5'd5,  5'd7,  5'd8 }},
    '{'{5'd18, 5'd19, 5'd21, 5'd22}, '{5'd19, 5'd20, 5'd22, 5'd23},
      '{5'd21, 5'd22, 5'd24, 5'd25}, '{5'd22, 5'd23, 5'd25, 5'd26}},
    '{'{5'd6,  5'd7,  5'd15, 5'd16}, '{5'd7,  5'd8,  5'd16, 5'd17},
      '{5'd15, 5'd16, 5'd24, 5'd25}, '{5'd16, 5'd17, 5'd25, 5'd26}},
    '{'{5'd0,  5'd1,  5'd9,  5'd10}, '{5'd1,  5'd2,  5'd10, 5'd11},
      '{5'd9,  5'd10, 5'd18, 5'd19}, '{5'd10, 5'd11, 5'd19, 5'd20}},
    '{'{5'd0,  5'd3,  5'd9,  5'd12}, '{5'd3,  5'd6,  5'd12, 5'd15},
      '{5'd9,  5'd12, 5'd18, 5'd21}, '{5'd12, 5'd15, 5'd21, 5'd24}},
    '{'{5'd2,  5'd5,  5'd11, 5'd14}, '{5'd5,  5'd8,  5'd14, 5'd17},
      '{5'd11, 5'd14, 5'd20, 5'd23}, '{5'd14, 5'd17, 5'd23, 5'd26}}
  };

  // nibble of neighbour n in a packed 27-nibble word
  function automatic logic [NIB_W-1:0] nibble_of(input logic [3*WORD_W-1:0] word,
                                                 input nbr_t n);
    logic [6:0] base;
    base = {n, 2'b00};
    return word[base +: NIB_W];
  endfunction

endpackage

// File: hdl/vcol_lane.sv
// one corner lane: occlusion and light sum of one corner of the selected face
module vcol_lane (
  input  vcol_pkg::nbhd_t     nbhd,
  input  vcol_pkg::face_t     face,
  input  vcol_pkg::corner_t   corner,
  output vcol_pkg::lane_res_t res
);

  logic       cn, s1, s2;
  logic [1:0] value;
  logic [5:0] ssum, lsum;
  logic [6:0] ao_raw;

  always_comb begin
    cn = nbhd.opaque[vcol_pkg::OCC_TRI[face][corner][0]];
    s1 = nbhd.opaque[vcol_pkg::OCC_TRI[face][corner][1]];
    s2 = nbhd.opaque[vcol_pkg::OCC_TRI[face][corner][2]];
    // two opaque sides hide the corner completely
    value = (s1 && s2) ? 2'd3 : ({1'b0, cn} + {1'b0, s1} + {1'b0, s2});
    ssum = 6'd0;
    lsum = 6'd0;
    for (int k = 0; k < 4; k++) begin
      ssum = ssum + {2'b00, vcol_pkg::nibble_of(nbhd.shade, vcol_pkg::OCC_QUAD[face][corner][k])};
      lsum = lsum + {2'b00, vcol_pkg::nibble_of(nbhd.light, vcol_pkg::OCC_QUAD[face][corner][k])};
    end
    ao_raw = {2'b00, value, 3'b000} + {1'b0, ssum};
    res.ao    = (ao_raw > vcol_pkg::AO_MAX) ? vcol_pkg::AO_MAX[5:0] : ao_raw[5:0];
    res.light = lsum;
  end

endmodule

// File: hdl/vcol_merge.sv
// merge stage: gathers the four lanes into one face result and holds it for the receiver
module vcol_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  vcol_pkg::lane_res_t lanes [vcol_pkg::NUM_CORNERS],
  input  vcol_pkg::face_t     face,
  input  logic                full,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [2:0]          out_face,
  output logic [5:0]          out_ao_0,
  output logic [5:0]          out_ao_1,
  output logic [5:0]          out_ao_2,
  output logic [5:0]          out_ao_3,
  output logic [9:0]          out_light_0,
  output logic [9:0]          out_light_1,
  output logic [9:0]          out_light_2,
  output logic [9:0]          out_light_3,
  output logic                out_is_last
);

  logic       valid_r, valid_nxt;
  logic [2:0] face_r;
  logic       last_r;
  logic [5:0] ao_r    [vcol_pkg::NUM_CORNERS];
  logic [9:0] light_r [vcol_pkg::NUM_CORNERS];

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      face_r <= face;
      last_r <= (face == vcol_pkg::LAST_FACE);
      for (int c = 0; c < vcol_pkg::NUM_CORNERS; c++) begin
        ao_r[c]    <= lanes[c].ao;
        // full centre light overrides every corner
        light_r[c] <= full ? vcol_pkg::FULL_LIGHT : {4'b0000, lanes[c].light};
      end
    end
  end

  assign out_valid   = valid_r;
  assign out_face    = face_r;
  assign out_is_last = last_r;
  assign out_ao_0    = ao_r[0];
  assign out_ao_1    = ao_r[1];
  assign out_ao_2    = ao_r[2];
  assign out_ao_3    = ao_r[3];
  assign out_light_0 = light_r[0];
  assign out_light_1 = light_r[1];
  assign out_light_2 = light_r[2];
  assign out_light_3 = light_r[3];

endmodule

// File: hdl/voxel_corner_occlusion_light.sv
// top level of the voxel corner occlusion and light block
//
// An input item carries one block's 3x3x3 neighbourhood: opaque bits plus
// packed light and shade nibbles. The block answers with six result items,
// one per face in table order, each with four corner occlusions and four
// corner light sums; is_last marks the sixth.
// Both channels are valid/ready. The accepted item is held in a register;
// four corner lanes work on one face per cycle while the output is free and
// the merge stage writes the face result into the output register.
// The accepted item is registered in the item holder; its first face then
// passes the lanes into the output register. Faces go out one per cycle,
// through the single output register, while the receiver takes them; the
// next item is taken in the cycle the current one's sixth face moves there.
// A stalled receiver holds the output register, which stops the face
// counter and so the input side. Synchronous active-low reset empties the
// item holder and the output register; no result is pending after it.
`include "voxel_corner_occlusion_light_macros.svh"

module voxel_corner_occlusion_light (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [26:0] in_opaque_mask,
  input  logic [35:0] in_light_low,
  input  logic [35:0] in_light_mid,
  input  logic [35:0] in_light_high,
  input  logic [35:0] in_shade_low,
  input  logic [35:0] in_shade_mid,
  input  logic [35:0] in_shade_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_face,
  output logic [5:0]  out_ao_0,
  output logic [5:0]  out_ao_1,
  output logic [5:0]  out_ao_2,
  output logic [5:0]  out_ao_3,
  output logic [9:0]  out_light_0,
  output logic [9:0]  out_light_1,
  output logic [9:0]  out_light_2,
  output logic [9:0]  out_light_3,
  output logic        out_is_last
);

  vcol_pkg::nbhd_t     nbhd_r;
  logic                busy_r, busy_nxt;
  vcol_pkg::face_t     face_r, face_nxt;
  logic                adv, at_last, accept, full;
  vcol_pkg::lane_res_t lanes [vcol_pkg::NUM_CORNERS];

  assign at_last  = (face_r == vcol_pkg::LAST_FACE);
  assign adv      = busy_r && (!out_valid || out_ready);
  assign in_ready = !busy_r || (adv && at_last);
  assign accept   = in_valid && in_ready;
  assign full     = (vcol_pkg::nibble_of(nbhd_r.light, vcol_pkg::CENTRE_NBR)
                     == vcol_pkg::LIGHT_FULL_LEVEL);

  always_comb begin
    if (accept) begin
      busy_nxt = 1'b1;
      face_nxt = vcol_pkg::FIRST_FACE;
    end else if (adv) begin
      busy_nxt = !at_last;
      face_nxt = at_last ? vcol_pkg::FIRST_FACE : face_r + 3'd1;
    end else begin
      busy_nxt = busy_r;
      face_nxt = face_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      face_r <= vcol_pkg::FIRST_FACE;
    end else begin
      busy_r <= busy_nxt;
      face_r <= face_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nbhd_r.opaque <= in_opaque_mask;
      nbhd_r.light  <= {in_light_high, in_light_mid, in_light_low};
      nbhd_r.shade  <= {in_shade_high, in_shade_mid, in_shade_low};
    end
  end

  for (genvar c = 0; c < vcol_pkg::NUM_CORNERS; c++) begin : g_lane
    vcol_lane u_lane (
      .nbhd   (nbhd_r),
      .face   (face_r),
      .corner (vcol_pkg::corner_t'(c)),
      .res    (lanes[c])
    );
  end

  vcol_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (adv),
    .lanes       (lanes),
    .face        (face_r),
    .full        (full),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_face    (out_face),
    .out_ao_0    (out_ao_0),
    .out_ao_1    (out_ao_1),
    .out_ao_2    (out_ao_2),
    .out_ao_3    (out_ao_3),
    .out_light_0 (out_light_0),
    .out_light_1 (out_light_1),
    .out_light_2 (out_light_2),
    .out_light_3 (out_light_3),
    .out_is_last (out_is_last)
  );

  // a new item only enters over the last face of the one before
  `VCOL_ASSERT_NOW(a_accept_on_last, accept && busy_r, adv && at_last)
  // the face counter never leaves the table
  `VCOL_ASSERT_NOW(a_face_range, busy_r, face_r <= vcol_pkg::LAST_FACE)
  // the marked result is the sixth face
  `VCOL_ASSERT_NOW(a_last_face, out_valid && out_is_last, out_face == vcol_pkg::LAST_FACE)
  // an item stays held until its sixth face has gone out
  `VCOL_ASSERT_NEXT(a_stay_busy, adv && !at_last, busy_r && face_r == $past(face_r) + 3'd1)

endmodule

// File: sim/vcol_checker.sv
// checker for the voxel corner occlusion light block: predicts and compares face results
module vcol_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [26:0] in_opaque_mask,
  input  logic [35:0] in_light_low,
  input  logic [35:0] in_light_mid,
  input  logic [35:0] in_light_high,
  input  logic [35:0] in_shade_low,
  input  logic [35:0] in_shade_mid,
  input  logic [35:0] in_shade_high,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_face,
  input  logic [5:0]  out_ao_0,
  input  logic [5:0]  out_ao_1,
  input  logic [5:0]  out_ao_2,
  input  logic [5:0]  out_ao_3,
  input  logic [9:0]  out_light_0,
  input  logic [9:0]  out_light_1,
  input  logic [9:0]  out_light_2,
  input  logic [9:0]  out_light_3,
  input  logic        out_is_last,
  output int          fail_count,
  output int          faces_pending,
  output int          faces_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FACE_COUNT   = 6;
  localparam int CENTRE       = 13;
  localparam int OCCL_CAP     = 32;
  localparam int LIGHT_FORCED = 600;

  // corner, side, side per face and corner
  localparam bit [4:0] CORNER_TRI [6][4][3] = '{
    '{'{5'd0,  5'd1,  5'd3 }, '{5'd2,  5'd1,  5'd5 }, '{5'd6,  5'd3,  5'd7 },
      '{5'd8,  5'd5,  5'd7 }},
    '{'{5'd18, 5'd19, 5'd21}, '{5'd20, 5'd19, 5'd23}, '{5'd24, 5'd21, 5'd25},
      '{5'd26, 5'd23, 5'd25}},
    '{'{5'd6,  5'd7,  5'd15}, '{5'd8,  5'd7,  5'd17}, '{5'd24, 5'd15, 5'd25},
      '{5'd26, 5'd17, 5'd25}},
    '{'{5'd0,  5'd1,  5'd9 }, '{5'd2,  5'd1,  5'd11}, '{5'd18, 5'd9,  5'd19},
      '{5'd20, 5'd11, 5'd19}},
    '{'{5'd0,  5'd3,  5'd9 }, '{5'd6,  5'd3,  5'd15}, '{5'd18, 5'd9,  5'd21},
      '{5'd24, 5'd15, 5'd21}},
    '{'{5'd2,  5'd5,  5'd11}, '{5'd8,  5'd5,  5'd17}, '{5'd20, 5'd11, 5'd23},
      '{5'd26, 5'd17, 5'd23}}
  };

  // the 2x2 patch of neighbours around each corner
  localparam bit [4:0] CORNER_QUAD [6][4][4] = '{
    '{'{5'd0,  5'd1,  5'd3,  5'd4 }, '{5'd1,  5'd2,  5'd4,  5'd5 },
      '{5'd3,  5'd4,  5'd6,  5'd7 }, '{5'd4,  5'd5,  5'd7,  5'd8 }},
    '{'{5'd18, 5'd19, 5'd21, 5'd22}, '{5'd19, 5'd20, 5'd22, 5'd23},
      '{5'd21, 5'd22, 5'd24, 5'd25}, '{5'd22, 5'd23, 5'd25, 5'd26}},
    '{'{5'd6,  5'd7,  5'd15, 5'd16}, '{5'd7,  5'd8,  5'd16, 5'd17},
      '{5'd15, 5'd16, 5'd24, 5'd25}, '{5'd16, 5'd17, 5'd25, 5'd26}},
    '{'{5'd0,  5'd1,  5'd9,  5'd10}, '{5'd1,  5'd2,  5'd10, 5'd11},
      '{5'd9,  5'd10, 5'd18, 5'd19}, '{5'd10, 5'd11, 5'd19, 5'd20}},
    '{'{5'd0,  5'd3,  5'd9,  5'd12}, '{5'd3,  5'd6,  5'd12, 5'd15},
      '{5'd9,  5'd12, 5'd18, 5'd21}, '{5'd12, 5'd15, 5'd21, 5'd24}},
    '{'{5'd2,  5'd5,  5'd11, 5'd14}, '{5'd5,  5'd8,  5'd14, 5'd17},
      '{5'd11, 5'd14, 5'd20, 5'd23}, '{5'd14, 5'd17, 5'd23, 5'd26}}
  };

  typedef struct packed {
    vcol_pkg::face_t face;
    logic [3:0][5:0] ao;
    logic [3:0][9:0] lt;
    logic            last;
  } face_result_t;

  face_result_t faces_due[$];
  int n_fail    = 0;
  int n_pending = 0;
  int n_checked = 0;

  assign fail_count    = n_fail;
  assign faces_pending = n_pending;
  assign faces_checked = n_checked;

  // six face results of one neighbourhood
  function automatic void predict_faces(input logic [26:0] mask, input logic [107:0] lights,
                                        input logic [107:0] shades);
    face_result_t r;
    int f, c, k, occ, shd_total, lit_total;
    bit full, cn, s1, s2;
    full = (lights[4*CENTRE +: 4] == 4'hF);
    for (f = 0; f < FACE_COUNT; f++) begin
      r.face = vcol_pkg::face_t'(f);
      r.last = (f == FACE_COUNT - 1);
      for (c = 0; c < 4; c++) begin
        cn = mask[CORNER_TRI[f][c][0]];
        s1 = mask[CORNER_TRI[f][c][1]];
        s2 = mask[CORNER_TRI[f][c][2]];
        // both sides opaque hide the corner regardless of itself
        occ = (s1 && s2) ? 3 : int'(cn) + int'(s1) + int'(s2);
        shd_total = 0;
        lit_total = 0;
        for (k = 0; k < 4; k++) begin
          shd_total += shades[4*CORNER_QUAD[f][c][k] +: 4];
          lit_total += lights[4*CORNER_QUAD[f][c][k] +: 4];
        end
        occ = 8 * occ + shd_total;
        if (occ > OCCL_CAP) occ = OCCL_CAP;
        if (full) lit_total = LIGHT_FORCED;
        r.ao[c] = occ[5:0];
        r.lt[c] = lit_total[9:0];
      end
      faces_due.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    face_result_t want, got;
    int c;
    if (rst_n) begin
      if (in_valid && in_ready)
        predict_faces(in_opaque_mask, {in_light_high, in_light_mid, in_light_low},
                      {in_shade_high, in_shade_mid, in_shade_low});
      if (out_valid && out_ready) begin
        got.face = out_face;
        got.ao   = {out_ao_3, out_ao_2, out_ao_1, out_ao_0};
        got.lt   = {out_light_3, out_light_2, out_light_1, out_light_0};
        got.last = out_is_last;
        if (faces_due.size() == 0) begin
          $error("face result with nothing pending: face %0d", got.face);
          n_fail++;
        end else begin
          want = faces_due.pop_front();
          n_checked++;
          if (got.face !== want.face) begin
            $error("face expected %0d actual %0d", want.face, got.face);
            n_fail++;
          end
          for (c = 0; c < 4; c++) begin
            if (got.ao[c] !== want.ao[c]) begin
              $error("ao_%0d expected %0d actual %0d", c, want.ao[c], got.ao[c]);
              n_fail++;
            end
            if (got.lt[c] !== want.lt[c]) begin
              $error("light_%0d expected %0d actual %0d", c, want.lt[c], got.lt[c]);
              n_fail++;
            end
          end
          if (got.last !== want.last) begin
            $error("is_last expected %0d actual %0d", want.last, got.last);
            n_fail++;
          end
        end
      end
      n_pending = faces_due.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// testbench top for the voxel corner occlusion light block: stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 367;
  localparam int CALM_FROM    = 150;
  localparam int CALM_TO      = 230;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [26:0] in_opaque_mask;
  logic [35:0] in_light_low, in_light_mid, in_light_high;
  logic [35:0] in_shade_low, in_shade_mid, in_shade_high;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_face;
  logic [5:0]  out_ao_0, out_ao_1, out_ao_2, out_ao_3;
  logic [9:0]  out_light_0, out_light_1, out_light_2, out_light_3;
  logic        out_is_last;

  int fail_count, faces_pending, faces_checked;
  int blocks_sent = 0;
  int faces_taken = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  bit calm        = 1'b0;

  voxel_corner_occlusion_light DUT (.*);
  vcol_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #500us;
    $display("status: fail");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) faces_taken++;
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (faces_taken >= HOLD_AT && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  task automatic send_block(input logic [26:0] mask, input logic [107:0] lights,
                            input logic [107:0] shades);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opaque_mask <= mask;
    in_light_low   <= lights[35:0];
    in_light_mid   <= lights[71:36];
    in_light_high  <= lights[107:72];
    in_shade_low   <= shades[35:0];
    in_shade_mid   <= shades[71:36];
    in_shade_high  <= shades[107:72];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    blocks_sent++;
  endtask

  // 27 nibbles; shades lean toward the nominal 0..8 range
  function automatic logic [107:0] random_levels(input bit as_shade);
    logic [107:0] w;
    int n, pick;
    pick = $urandom_range(9);
    for (n = 0; n < 27; n++) begin
      if (pick <= 2)
        w[4*n +: 4] = 4'($urandom_range(15));
      else if (pick <= 4)
        w[4*n +: 4] = 4'($urandom_range(3));
      else if (pick <= 8)
        w[4*n +: 4] = as_shade ? 4'($urandom_range(8)) : 4'($urandom_range(15, 12));
      else
        w[4*n +: 4] = $urandom_range(1) ? (as_shade ? 4'd8 : 4'd15) : 4'd0;
    end
    return w;
  endfunction

  function automatic logic [26:0] random_mask();
    case ($urandom_range(3))
      0: return 27'($urandom);
      1: return 27'($urandom & $urandom);
      2: return 27'($urandom | $urandom);
      default: return $urandom_range(1) ? 27'h7FFFFFF : 27'h0;
    endcase
  endfunction

  initial begin
    logic [107:0] lv;
    int i;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opaque_mask <= '0;
    in_light_low   <= '0;
    in_light_mid   <= '0;
    in_light_high  <= '0;
    in_shade_low   <= '0;
    in_shade_mid   <= '0;
    in_shade_high  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_block(27'h0, '0, '0);
    send_block(27'h7FFFFFF, '0, '0);
    // shade nibbles above eight and the centre at full light
    send_block(27'h7FFFFFF, {27{4'hF}}, {27{4'hF}});
    lv = {27{4'hF}};
    lv[4*13 +: 4] = 4'hE;
    send_block(27'h0, lv, '0);
    lv = '0;
    lv[4*13 +: 4] = 4'hF;
    send_block(27'h0, lv, {27{4'h3}});
    send_block(27'h0, {27{4'h1}}, {27{4'h8}});
    send_block(27'h0, {27{4'h1}}, {27{4'h1}});
    send_block(27'h5555555, {27{4'hA}}, {27{4'h5}});
    send_block(27'h2AAAAAA, {27{4'h5}}, {27{4'hA}});
    // cube corners alone, then edge neighbours alone (both sides set)
    send_block(27'h5140145, {27{4'h7}}, '0);
    send_block(27'h2AA8AAA, {27{4'h2}}, '0);
    send_block(27'h0000002, {27{4'hC}}, {27{4'h2}});
    send_block(27'h0, {27{4'h9}}, {27{4'h9}});

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= CALM_FROM && i < CALM_TO);
      send_block(random_mask(), random_levels(1'b0), random_levels(1'b1));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (faces_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d neighbourhoods, compared %0d face results field by field",
             blocks_sent, faces_checked);
    $display("covered solid, empty, full-light and over-range shade cases plus a long stall");
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
